// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl module pvsd_core
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PVSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pvsd assertion failed");
`define PVSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pvsd forbidden condition seen");
`else
`define PVSD_ASSERT(lbl, clk, rst_n, prop)
`define PVSD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/pvsd_pkg.sv =====
// types and constants of the packed varint sequence decoder
// no dependencies
`default_nettype none

package pvsd_pkg;

  localparam int CountBits    = 27;
  localparam int MaxItemsBits = 27;
  localparam int CmpBits      = (CountBits > MaxItemsBits ? CountBits : MaxItemsBits) + 1;
  localparam int ShiftBits    = 7;

  localparam logic [MaxItemsBits-1:0] MaxItemsReset = MaxItemsBits'(100000000);

  localparam logic [7:0] ByteNotFound = 8'h40;
  localparam logic [7:0] ByteInvalid  = 8'h41;
  localparam logic [7:0] ByteEndSeq   = 8'h42;

  localparam logic [ShiftBits-1:0] GroupBits = ShiftBits'(7);
  localparam logic [ShiftBits-1:0] ShiftMax  = ShiftBits'(64);
  localparam logic [ShiftBits-1:0] ShiftTop  = ShiftBits'(70);

  localparam logic [1:0] KindNumber  = 2'd0;
  localparam logic [1:0] KindEndSeq  = 2'd1;
  localparam logic [1:0] KindEndFile = 2'd2;
  localparam logic [1:0] KindError   = 2'd3;

  localparam logic [1:0] ErrBadFinal  = 2'd0;
  localparam logic [1:0] ErrTooLong   = 2'd1;
  localparam logic [1:0] ErrTruncated = 2'd2;
  localparam logic [1:0] ErrTooMany   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] number;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } core_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/packed_varint_sequence_decoder.sv =====
// Packed varint sequence decoder, top level.
// Input channel: in_valid_i / in_stall_o carry one byte or an end-of-input
// mark per transfer. Output channel: out_valid_o / out_stall_i carry one
// result (number, end of sequence, end of file or error) per transfer.
// Config channel: cfg_valid_i / cfg_ready_o writes max_items; write it only
// while the block is idle.
// Path: a byte waits in the input register and its result in the result
// register, from which it transfers on the output when out_stall_i is low.
// Throughput: one byte per cycle, save for the output stall below; the decode
// state (accumulator, shift, item count) updates in logic between the two registers.
// A stalled output holds its result; the input register keeps taking bytes
// that produce no result, and stalls the input when a byte with a result
// cannot move into the occupied result register.
// Reset clears the decode state, sets max_items to 100000000 and empties
// both registers. After an error or end of file no further results appear
// until reset.
// depends on pvsd_pkg, pvsd_in_reg, pvsd_core
`default_nettype none

module packed_varint_sequence_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pvsd_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pvsd_pkg::out_item_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pvsd_pkg::MaxItemsBits-1:0]  cfg_data_i
);
  import pvsd_pkg::*;

  logic                    hold_valid;
  in_item_t                hold_item;
  logic                    step;
  core_res_t               res;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q;
  logic [MaxItemsBits-1:0] max_items_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_items_q <= MaxItemsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_items_q <= cfg_data_i;
    end
  end

  pvsd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .take_i       (step),
    .hold_valid_o (hold_valid),
    .hold_item_o  (hold_item)
  );

  pvsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (hold_item),
    .max_items_i (max_items_q),
    .res_o       (res)
  );

  // an item moves on when its result has room, or it has no result
  assign step = hold_valid && (!out_valid_q || !out_stall_i || !res.emit);

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pvsd_in_reg.sv =====
// input register stage of the packed varint sequence decoder
// depends on pvsd_pkg
`default_nettype none

module pvsd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pvsd_pkg::in_item_t in_item_i,
  input  logic               take_i,
  output logic               hold_valid_o,
  output pvsd_pkg::in_item_t hold_item_o
);
  import pvsd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = (take_i || !valid_q) ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pvsd_core.sv =====
// decode state and per-byte next-state logic of the packed varint sequence decoder
// depends on pvsd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module pvsd_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  pvsd_pkg::in_item_t                  item_i,
  input  logic [pvsd_pkg::MaxItemsBits-1:0]   max_items_i,
  output pvsd_pkg::core_res_t                 res_o
);
  import pvsd_pkg::*;

  logic [63:0]          acc_q, acc_d;
  logic [ShiftBits-1:0] shift_q, shift_d;
  logic                 inside_q, inside_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 halted_q, halted_d;

  logic [63:0]          base_acc;
  logic [ShiftBits-1:0] base_shift;
  logic [63:0]          cont_acc;
  logic [63:0]          final_val;
  logic                 item_req;
  logic [63:0]          item_val;
  logic                 fail_req;
  logic [1:0]           fail_code;
  logic [CmpBits-1:0]   next_count;
  core_res_t            res;

  assign base_acc   = inside_q ? acc_q : 64'd0;
  assign base_shift = inside_q ? shift_q : '0;
  assign cont_acc   = base_acc | ({57'd0, item_i.data_byte[6:0]} << base_shift[5:0]);
  assign final_val  = base_acc | ({58'd0, item_i.data_byte[5:0]} << base_shift[5:0]);
  assign next_count = CmpBits'(count_q) + CmpBits'(1);

  always_comb begin
    acc_d     = acc_q;
    shift_d   = shift_q;
    inside_d  = inside_q;
    count_d   = count_q;
    halted_d  = halted_q;
    item_req  = 1'b0;
    item_val  = 64'd0;
    fail_req  = 1'b0;
    fail_code = ErrBadFinal;
    res       = '0;
    if (!halted_q) begin
      priority if (item_i.end_of_input) begin
        priority if (inside_q) begin
          fail_req  = 1'b1;
          fail_code = ErrTruncated;
        end else if (count_q == '0) begin
          halted_d      = 1'b1;
          res.emit      = 1'b1;
          res.item.kind = KindEndFile;
        end else begin
          count_d       = '0;
          res.emit      = 1'b1;
          res.item.kind = KindEndSeq;
        end
      end else if (!inside_q && item_i.data_byte == ByteNotFound) begin
        item_req = 1'b1;
        item_val = '1;
      end else if (!inside_q && item_i.data_byte == ByteInvalid) begin
        item_req = 1'b1;
        item_val = ~64'd1;
      end else if (!inside_q && item_i.data_byte == ByteEndSeq) begin
        count_d       = '0;
        res.emit      = 1'b1;
        res.item.kind = KindEndSeq;
      end else if (inside_q && shift_q > ShiftMax) begin
        fail_req  = 1'b1;
        fail_code = ErrTooLong;
      end else if (item_i.data_byte[7]) begin
        acc_d    = cont_acc;
        shift_d  = base_shift + GroupBits;
        inside_d = 1'b1;
      end else if (item_i.data_byte[6]) begin
        fail_req  = 1'b1;
        fail_code = ErrBadFinal;
      end else begin
        item_req = 1'b1;
        item_val = final_val;
      end

      if (item_req) begin
        if (next_count > CmpBits'(max_items_i) || count_q == '1) begin
          fail_req  = 1'b1;
          fail_code = ErrTooMany;
        end else begin
          count_d         = CountBits'(next_count);
          acc_d           = 64'd0;
          shift_d         = '0;
          inside_d        = 1'b0;
          res.emit        = 1'b1;
          res.item.kind   = KindNumber;
          res.item.number = item_val;
        end
      end

      if (fail_req) begin
        halted_d            = 1'b1;
        inside_d            = 1'b0;
        acc_d               = 64'd0;
        shift_d             = '0;
        res.emit            = 1'b1;
        res.item.kind       = KindError;
        res.item.number     = 64'd0;
        res.item.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 64'd0;
      shift_q  <= '0;
      inside_q <= 1'b0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      inside_q <= inside_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

  assign res_o = res;

  `PVSD_ASSERT(a_shift_range, clk_i, rst_ni, shift_q <= ShiftTop)
  `PVSD_ASSERT(a_halt_sticky, clk_i, rst_ni, halted_q |=> halted_q)
  `PVSD_ASSERT(a_acc_idle_zero, clk_i, rst_ni, !inside_q |-> (acc_q == 64'd0 && shift_q == '0))
  `PVSD_ASSERT(a_error_halts, clk_i, rst_ni,
               (step_i && res.emit && res.item.kind == KindError) |=> halted_q)
  `PVSD_ASSERT_NEVER(a_silent_halted, clk_i, rst_ni, halted_q && res.emit)

endmodule

`default_nettype wire
